/* design/sadt_pkg.sv */
// ----------------------------------------------------------------------------
// sadt_pkg
// Shared constants for the sin/cos angle delta tracker: the CORDIC arctangent
// table, fixed-point widths and parameter defaults.
// ----------------------------------------------------------------------------
package sadt_pkg;

  localparam int SAMPLE_BITS_DEF   = 10;
  localparam int ANGLE_BITS_DEF    = 16;
  localparam int CORDIC_STAGES_DEF = 16;

  localparam int MID_BITS  = 10;
  localparam int OUT_BITS  = 16;
  localparam int ACC_BITS  = 32;
  localparam int FRAC_BITS = 24;
  localparam int TABLE_LEN = 24;

  localparam logic [MID_BITS-1:0] MID_RESET = 10'd512;
  localparam logic [ACC_BITS-1:0] HALF_TURN = 32'h8000_0000;

  // atan(2^-i) in binary angle, full turn = 2^32
  localparam logic [ACC_BITS-1:0] ATAN_TURNS [TABLE_LEN] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
  };

endpackage

/* design/sadt_prep.sv */
// ----------------------------------------------------------------------------
// sadt_prep
// Front cell: holds the midpoint register, centers both readings, folds the
// vector into the right half plane and scales it into CORDIC fixed point.
// ----------------------------------------------------------------------------
module sadt_prep #(
  parameter int SAMPLE_BITS = sadt_pkg::SAMPLE_BITS_DEF,
  parameter int XW          = 37
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [sadt_pkg::MID_BITS-1:0]  cfg_wr_data,
  input  logic                           up_valid,
  output logic                           up_stall,
  input  logic [SAMPLE_BITS-1:0]         up_a,
  input  logic [SAMPLE_BITS-1:0]         up_b,
  output logic                           dn_valid,
  input  logic                           dn_stall,
  output logic signed [XW-1:0]           dn_x,
  output logic signed [XW-1:0]           dn_y,
  output logic [sadt_pkg::ACC_BITS-1:0]  dn_acc,
  output logic                           dn_zero
);

  localparam int DW = ((SAMPLE_BITS > sadt_pkg::MID_BITS) ? SAMPLE_BITS
                                                          : sadt_pkg::MID_BITS) + 1;
  localparam int FW = sadt_pkg::FRAC_BITS;

  logic [sadt_pkg::MID_BITS-1:0] mid_r;
  logic signed [DW-1:0]          mid_s, a_s, b_s, xc, yc, xf, yf;
  logic                          valid_r;
  logic signed [XW-1:0]          x_r, y_r;
  logic [sadt_pkg::ACC_BITS-1:0] acc_r, acc_nxt;
  logic                          zero_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= sadt_pkg::MID_RESET;
    end else if (cfg_wr_en) begin
      mid_r <= cfg_wr_data;
    end
  end

  assign mid_s = signed'(DW'(mid_r));
  assign a_s   = signed'(DW'(up_a));
  assign b_s   = signed'(DW'(up_b));
  assign yc    = a_s - mid_s;
  assign xc    = b_s - mid_s;

  always_comb begin
    if (xc[DW-1]) begin
      xf      = -xc;
      yf      = -yc;
      acc_nxt = sadt_pkg::HALF_TURN;
    end else begin
      xf      = xc;
      yf      = yc;
      acc_nxt = '0;
    end
  end

  assign up_stall = valid_r && dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      x_r    <= {{(XW-DW-FW){xf[DW-1]}}, xf, {FW{1'b0}}};
      y_r    <= {{(XW-DW-FW){yf[DW-1]}}, yf, {FW{1'b0}}};
      acc_r  <= acc_nxt;
      zero_r <= (xc == '0) && (yc == '0);
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_acc   = acc_r;
  assign dn_zero  = zero_r;

endmodule

/* design/sadt_cell.sv */
// ----------------------------------------------------------------------------
// sadt_cell
// One vectoring CORDIC micro-rotation with its own register and valid bit.
// ----------------------------------------------------------------------------
module sadt_cell #(
  parameter int XW    = 37,
  parameter int STAGE = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_stall,
  input  logic signed [XW-1:0]           up_x,
  input  logic signed [XW-1:0]           up_y,
  input  logic [sadt_pkg::ACC_BITS-1:0]  up_acc,
  input  logic                           up_zero,
  output logic                           dn_valid,
  input  logic                           dn_stall,
  output logic signed [XW-1:0]           dn_x,
  output logic signed [XW-1:0]           dn_y,
  output logic [sadt_pkg::ACC_BITS-1:0]  dn_acc,
  output logic                           dn_zero
);

  localparam logic [sadt_pkg::ACC_BITS-1:0] TURN = sadt_pkg::ATAN_TURNS[STAGE];

  logic signed [XW-1:0]          xs, ys, x_nxt, y_nxt, x_r, y_r;
  logic [sadt_pkg::ACC_BITS-1:0] acc_nxt, acc_r;
  logic                          valid_r, zero_r;

  // arithmetic shift floors, matching the fixed-point definition
  assign xs = up_x >>> STAGE;
  assign ys = up_y >>> STAGE;

  always_comb begin
    if (!up_y[XW-1]) begin
      x_nxt   = up_x + ys;
      y_nxt   = up_y - xs;
      acc_nxt = up_acc + TURN;
    end else begin
      x_nxt   = up_x - ys;
      y_nxt   = up_y + xs;
      acc_nxt = up_acc - TURN;
    end
  end

  assign up_stall = valid_r && dn_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!up_stall) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      acc_r  <= acc_nxt;
      zero_r <= up_zero;
    end
  end

  assign dn_valid = valid_r;
  assign dn_x     = x_r;
  assign dn_y     = y_r;
  assign dn_acc   = acc_r;
  assign dn_zero  = zero_r;

endmodule

/* design/sadt_out.sv */
// ----------------------------------------------------------------------------
// sadt_out
// Last cell: rounds the accumulator to the output angle, differences it
// against the previous angle and holds the result register.
// ----------------------------------------------------------------------------
module sadt_out #(
  parameter int ANGLE_BITS = sadt_pkg::ANGLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           up_valid,
  output logic                           up_stall,
  input  logic [sadt_pkg::ACC_BITS-1:0]  up_acc,
  input  logic                           up_zero,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [sadt_pkg::OUT_BITS-1:0] out_angle_delta,
  output logic [sadt_pkg::OUT_BITS-1:0]  out_angle_now
);

  localparam int AW = sadt_pkg::ACC_BITS;
  localparam int EW = (ANGLE_BITS > sadt_pkg::OUT_BITS) ? ANGLE_BITS : sadt_pkg::OUT_BITS;
  localparam logic [AW-1:0] RND = AW'(1) << (AW - 1 - ANGLE_BITS);

  logic [AW-1:0]          acc_rnd;
  logic [ANGLE_BITS-1:0]  now, diff, last_r;
  logic signed [EW-1:0]   diff_ext;
  logic [EW-1:0]          now_ext;
  logic                   valid_r;
  logic [sadt_pkg::OUT_BITS-1:0] delta_r, now_r;

  assign acc_rnd  = up_acc + RND;
  assign now      = up_zero ? '0 : acc_rnd[AW-1 -: ANGLE_BITS];
  assign diff     = now - last_r;
  assign diff_ext = EW'(signed'(diff));
  assign now_ext  = EW'(now);

  assign up_stall = valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= '0;
    end else begin
      if (!up_stall) begin
        valid_r <= up_valid;
      end
      if (up_valid && !up_stall) begin
        last_r <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && !up_stall) begin
      delta_r <= diff_ext[sadt_pkg::OUT_BITS-1:0];
      now_r   <= now_ext[sadt_pkg::OUT_BITS-1:0];
    end
  end

  assign out_valid       = valid_r;
  assign out_angle_delta = signed'(delta_r);
  assign out_angle_now   = now_r;

endmodule

/* design/sincos_angle_delta_tracker.sv */
// ----------------------------------------------------------------------------
// sincos_angle_delta_tracker
// Angle and angle change of a magnet from two quadrature analog sensors,
// computed by a pipelined vectoring CORDIC.
//
// Usage:
//   cfg_wr_en/cfg_wr_data write the sensor midpoint (reset 512); write it only
//   while no request is in flight.
//   Input request: in_sample_a (y) and in_sample_b (x), taken when in_valid is
//   high and in_stall low. Result request: out_angle_now (full turn = 2^16)
//   and out_angle_delta (change from the previous angle, in [-half, +half)),
//   taken when out_valid is high and out_stall low.
//   The pipeline is a centering cell, one cell per CORDIC rotation and an
//   output cell; one request enters per cycle while in_stall is low. Each
//   cell has its own valid bit, so bubbles close up while the receiver
//   stalls and the input keeps being taken until every cell is full; the
//   result register holds its request steady while out_stall is high.
//   Reset empties the pipeline, sets the midpoint to 512 and the previous
//   angle to 0.
// ----------------------------------------------------------------------------
module sincos_angle_delta_tracker #(
  parameter int SAMPLE_BITS   = sadt_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS    = sadt_pkg::ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = sadt_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [sadt_pkg::MID_BITS-1:0]        cfg_wr_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [SAMPLE_BITS-1:0]               in_sample_a,
  input  logic [SAMPLE_BITS-1:0]               in_sample_b,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [sadt_pkg::OUT_BITS-1:0] out_angle_delta,
  output logic [sadt_pkg::OUT_BITS-1:0]        out_angle_now
);

  localparam int DW = ((SAMPLE_BITS > sadt_pkg::MID_BITS) ? SAMPLE_BITS
                                                          : sadt_pkg::MID_BITS) + 1;
  // two guard bits cover the CORDIC gain on a diagonal vector
  localparam int XW = DW + 2 + sadt_pkg::FRAC_BITS;
  localparam int N  = CORDIC_STAGES;

  logic                          vld   [N+1];
  logic                          stl   [N+1];
  logic signed [XW-1:0]          xv    [N+1];
  logic signed [XW-1:0]          yv    [N+1];
  logic [sadt_pkg::ACC_BITS-1:0] accv  [N+1];
  logic                          zerov [N+1];

  sadt_prep #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .XW          (XW)
  ) u_prep (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .up_valid    (in_valid),
    .up_stall    (in_stall),
    .up_a        (in_sample_a),
    .up_b        (in_sample_b),
    .dn_valid    (vld[0]),
    .dn_stall    (stl[0]),
    .dn_x        (xv[0]),
    .dn_y        (yv[0]),
    .dn_acc      (accv[0]),
    .dn_zero     (zerov[0])
  );

  for (genvar i = 0; i < N; i++) begin : g_cell
    sadt_cell #(
      .XW    (XW),
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (vld[i]),
      .up_stall (stl[i]),
      .up_x     (xv[i]),
      .up_y     (yv[i]),
      .up_acc   (accv[i]),
      .up_zero  (zerov[i]),
      .dn_valid (vld[i+1]),
      .dn_stall (stl[i+1]),
      .dn_x     (xv[i+1]),
      .dn_y     (yv[i+1]),
      .dn_acc   (accv[i+1]),
      .dn_zero  (zerov[i+1])
    );
  end

  sadt_out #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .up_valid        (vld[N]),
    .up_stall        (stl[N]),
    .up_acc          (accv[N]),
    .up_zero         (zerov[N]),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_angle_delta (out_angle_delta),
    .out_angle_now   (out_angle_now)
  );

  // final-cell x and y carry the vector magnitude; the angle needs only acc
  logic unused_xy;
  assign unused_xy = ^{xv[N], yv[N]};

endmodule

/* design/sadt_chk.sv */
// ----------------------------------------------------------------------------
// sadt_chk
// Port-level checks for the angle delta tracker, bound to the top level.
// ----------------------------------------------------------------------------
module sadt_chk #(
  parameter int SAMPLE_BITS = sadt_pkg::SAMPLE_BITS_DEF,
  parameter int ANGLE_BITS  = sadt_pkg::ANGLE_BITS_DEF
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic [SAMPLE_BITS-1:0]               in_sample_a,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [sadt_pkg::OUT_BITS-1:0] out_angle_delta,
  input logic [sadt_pkg::OUT_BITS-1:0]        out_angle_now
);

  logic [sadt_pkg::OUT_BITS-1:0] prev_now_r;
  logic                          chk_unused;

  assign chk_unused = ^{in_valid, in_stall, in_sample_a};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_now_r <= '0;
    end else if (out_valid && !out_stall) begin
      prev_now_r <= out_angle_now;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_angle_now) && $stable(out_angle_delta))
    else $error("result payload changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  if (ANGLE_BITS == sadt_pkg::OUT_BITS) begin : g_delta
    a_delta: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid |-> out_angle_delta == signed'(out_angle_now - prev_now_r))
      else $error("angle delta does not match previous angle");
  end

endmodule

bind sincos_angle_delta_tracker sadt_chk #(
  .SAMPLE_BITS (SAMPLE_BITS),
  .ANGLE_BITS  (ANGLE_BITS)
) u_sadt_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_sample_a     (in_sample_a),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_angle_delta (out_angle_delta),
  .out_angle_now   (out_angle_now)
);

/* tb/tb_sincos_angle_delta_tracker.sv */
// ----------------------------------------------------------------------------
// tb_sincos_angle_delta_tracker
// Self-checking bench for the CORDIC angle/delta tracker. Requests are queued
// by the stimulus process and sent by a clocked driver. An in-bench CORDIC
// predictor computes the angle and the wrapped change for each accepted
// request. A clocked monitor compares every result request, in order. The
// stimulus covers directed axis, diagonal and half-turn cases, rotating-magnet
// sequences and noise under several midpoint settings, with random idles on
// both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_sincos_angle_delta_tracker;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  SBITS      = sadt_pkg::SAMPLE_BITS_DEF;
  localparam int  MBITS      = sadt_pkg::MID_BITS;
  localparam int  LATENCY    = sadt_pkg::CORDIC_STAGES_DEF + 2;
  localparam int  IDLE_PCT   = 28;
  localparam int  HOLD_AT    = 600;
  localparam int  HOLD_LEN   = 80;
  localparam int  WDOG_LIMIT = 2000;
  localparam real PI_R       = 3.14159265358979;

  typedef struct packed {
    logic [SBITS-1:0] a;
    logic [SBITS-1:0] b;
  } sensor_pair_t;

  typedef struct packed {
    logic signed [sadt_pkg::OUT_BITS-1:0] delta;
    logic [sadt_pkg::OUT_BITS-1:0]        now;
  } angle_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [MBITS-1:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SBITS-1:0] in_sample_a = '0;
  logic [SBITS-1:0] in_sample_b = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [sadt_pkg::OUT_BITS-1:0] out_angle_delta;
  logic [sadt_pkg::OUT_BITS-1:0] out_angle_now;

  sensor_pair_t  sample_queue[$];
  angle_result_t angle_queue[$];
  sensor_pair_t  drive_pair;
  angle_result_t want;

  logic [MBITS-1:0] midpoint_cfg = sadt_pkg::MID_RESET;
  logic [15:0]         heading_prev = '0;
  logic                steady = 1'b0;
  int                  errors = 0;
  int                  results_seen = 0;
  int                  hold_left = 0;
  bit                  hold_done = 1'b0;
  int                  quiet_cycles = 0;

  sincos_angle_delta_tracker i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_a    (in_sample_a),
    .in_sample_b    (in_sample_b),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_angle_delta(out_angle_delta),
    .out_angle_now  (out_angle_now)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // vectoring CORDIC, 2^24 prescale, 32-bit turn accumulator
  function automatic logic [15:0] cordic_angle(int xi, int yi);
    longint      x;
    longint      y;
    longint      xs;
    longint      ys;
    logic [31:0] acc;
    if (xi == 0 && yi == 0) return '0;
    acc = '0;
    x = xi;
    y = yi;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = sadt_pkg::HALF_TURN;
    end
    x = x * (longint'(1) << sadt_pkg::FRAC_BITS);
    y = y * (longint'(1) << sadt_pkg::FRAC_BITS);
    for (int i = 0; i < sadt_pkg::CORDIC_STAGES_DEF && i < sadt_pkg::TABLE_LEN; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        acc = acc + sadt_pkg::ATAN_TURNS[i];
      end else begin
        x = x - ys;
        y = y + xs;
        acc = acc - sadt_pkg::ATAN_TURNS[i];
      end
    end
    acc = acc + (32'd1 << (31 - sadt_pkg::ANGLE_BITS_DEF));
    return acc[31:16];
  endfunction

  task automatic predict_angle(logic [SBITS-1:0] a, logic [SBITS-1:0] b);
    angle_result_t r;
    logic [15:0]   now;
    logic [15:0]   diff;
    now  = cordic_angle(int'({1'b0, b}) - int'({1'b0, midpoint_cfg}),
                        int'({1'b0, a}) - int'({1'b0, midpoint_cfg}));
    diff = now - heading_prev;
    heading_prev = now;
    r.delta = $signed(diff);
    r.now   = now;
    angle_queue.push_back(r);
  endtask

  task automatic report_mismatch(string what, int got, int want_v);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want_v, $realtime);
    errors++;
  endtask

  // driver: sends queued requests, holds payload while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_angle(in_sample_a, in_sample_b);
      if (!in_valid || !in_stall) begin
        if (sample_queue.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
          drive_pair = sample_queue.pop_front();
          in_valid    <= 1'b1;
          in_sample_a <= drive_pair.a;
          in_sample_b <= drive_pair.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks results, drives out_stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (angle_queue.size() == 0) begin
          report_mismatch("unexpected result, angle", out_angle_now, -1);
        end else begin
          want = angle_queue.pop_front();
          if (out_angle_now !== want.now)
            report_mismatch("angle_now", out_angle_now, want.now);
          if (out_angle_delta !== want.delta)
            report_mismatch("angle_delta", out_angle_delta, want.delta);
        end
      end
      // one long hold-off so the pipeline fills and backs up the input
      if (!hold_done && results_seen >= HOLD_AT) begin
        hold_left = HOLD_LEN;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SBITS-1:0] to_code(real v);
    if (v <= 0.0) return '0;
    if (v >= 1023.0) return '1;
    return SBITS'($rtoi(v + 0.5));
  endfunction

  task automatic add_pair(int a, int b);
    sensor_pair_t p;
    p.a = a[SBITS-1:0];
    p.b = b[SBITS-1:0];
    sample_queue.push_back(p);
  endtask

  // magnet turning around the current midpoint
  task automatic add_rotation(int n);
    real th;
    real step;
    real r;
    sensor_pair_t p;
    r  = $urandom_range(0, 540);
    th = $urandom_range(0, 6283) / 1000.0;
    if ($urandom_range(9) == 0)
      step = PI_R * ($urandom_range(0, 2000) / 1000.0 - 1.0);
    else
      step = 0.3 * ($urandom_range(0, 2000) / 1000.0 - 1.0);
    for (int k = 0; k < n; k++) begin
      p.a = to_code(real'(midpoint_cfg) + r * $sin(th));
      p.b = to_code(real'(midpoint_cfg) + r * $cos(th));
      sample_queue.push_back(p);
      th = th + step;
    end
  endtask

  task automatic add_mix(int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      if ($urandom_range(9) < 7) begin
        len = $urandom_range(10, 40);
        if (len > left) len = left;
        add_rotation(len);
      end else begin
        len = $urandom_range(1, 8);
        if (len > left) len = left;
        for (int k = 0; k < len; k++)
          add_pair($urandom_range(0, 1023), $urandom_range(0, 1023));
      end
      left -= len;
    end
  endtask

  task automatic wait_drained();
    do @(posedge clk);
    while (sample_queue.size() > 0 || in_valid || angle_queue.size() > 0);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_midpoint(logic [MBITS-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    midpoint_cfg = v;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset midpoint of 512
    add_pair(512, 512);    // zero vector
    add_pair(512, 1023);   // +x axis
    add_pair(512, 0);      // -x axis: change of exactly half a turn
    add_pair(1023, 512);   // +y axis
    add_pair(0, 512);      // -y axis
    add_pair(1023, 1023);
    add_pair(0, 0);
    add_pair(0, 1023);
    add_pair(1023, 0);
    add_pair(512, 512);    // zero vector after a nonzero angle
    add_pair(513, 512);
    add_pair(511, 512);
    add_pair(512, 513);
    add_pair(512, 511);
    add_pair(513, 0);      // just either side of the -x axis
    add_pair(511, 0);
    add_pair(512, 1023);
    add_pair(1023, 1023);
    wait_drained();

    steady = 1'b1;
    write_midpoint(10'd0);
    add_mix(200);
    wait_drained();
    steady = 1'b0;

    write_midpoint(10'd1023);
    add_mix(200);
    wait_drained();

    write_midpoint(sadt_pkg::MID_RESET);
    add_mix(500);
    wait_drained();

    repeat (3) begin
      write_midpoint(MBITS'($urandom_range(0, 1023)));
      add_mix(260);
      wait_drained();
    end

    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0 && angle_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
